@@ src/dlf_pkg.sv @@
`default_nettype none
package dlf_pkg;

    // Parameter defaults
    localparam int INPUT_MAX_DEF  = 1024;
    localparam int OUTPUT_MAX_DEF = 1024;

    // Field widths fixed by the stream format
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 16;
    localparam int WORD_W  = 32;
    localparam int ROWN_W  = 10;
    localparam int CNT_W   = 11;
    localparam int ACC_W   = 48;
    localparam int TOT_W   = 41;

    // Item kinds carried on tuser
    localparam logic [MODE_W-1:0] MODE_ACT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd2;

    // Configuration register indexes and reset value
    localparam int                REG_INPUT_COUNT = 0;
    localparam logic [CNT_W-1:0]  CNT_RESET       = 11'd1024;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int PEND_W     = 4;

    // Item entering the arithmetic pipeline
    typedef struct packed {
        logic                     mac;
        logic                     close;
        logic signed [VALUE_W-1:0] weight;
        logic signed [WORD_W-1:0]  bias;
        logic signed [WORD_W-1:0]  prior;
        logic [ROWN_W-1:0]        row;
        logic                     cerr;
    } t_stage_a;

    // One finished row
    typedef struct packed {
        logic                     sat;
        logic                     cerr;
        logic [ROWN_W-1:0]        row;
        logic [WORD_W-1:0]        value;
    } t_result;

endpackage
`default_nettype wire

@@ src/dlf_act_mem.sv @@
`default_nettype none
module dlf_act_mem
    import dlf_pkg::*;
#(
    parameter int DEPTH = INPUT_MAX_DEF,
    parameter int AW    = $clog2(INPUT_MAX_DEF)
) (
    input  wire                i_clk,
    input  wire                i_wr_en,
    input  wire [AW-1:0]       i_wr_addr,
    input  wire [VALUE_W-1:0]  i_wr_data,
    input  wire                i_rd_en,
    input  wire [AW-1:0]       i_rd_addr,
    output logic [VALUE_W-1:0] o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ src/dlf_datapath.sv @@
`default_nettype none
module dlf_datapath
    import dlf_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_stage_a          i_a,
    input  wire [VALUE_W-1:0] i_act,
    output logic              o_push,
    output t_result           o_res
);

    // Multiply stage
    logic                      r_b_mac;
    logic                      r_b_close;
    logic signed [WORD_W-1:0]  r_b_prod;
    logic signed [WORD_W:0]    r_b_pb;
    logic [ROWN_W-1:0]         r_b_row;
    logic                      r_b_cerr;

    // Accumulate stage
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_c_valid;
    logic signed [TOT_W-1:0]   r_c_tot;
    logic [ROWN_W-1:0]         r_c_row;
    logic                      r_c_cerr;

    logic                      w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_mac   <= 1'b0;
            r_b_close <= 1'b0;
        end else begin
            r_b_mac   <= i_a.mac;
            r_b_close <= i_a.close;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_prod <= $signed(i_act) * i_a.weight;
        r_b_pb   <= (WORD_W+1)'(i_a.bias) + (WORD_W+1)'(i_a.prior);
        r_b_row  <= i_a.row;
        r_b_cerr <= i_a.cerr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_close;
            if (r_b_close) begin
                r_acc <= '0;
            end else if (r_b_mac) begin
                r_acc <= r_acc + ACC_W'(r_b_prod);
            end
        end
    end

    // Floor divide by 256 is an arithmetic shift: drop the low byte
    always_ff @(posedge i_clk) begin
        r_c_tot  <= TOT_W'(r_b_pb) + TOT_W'($signed(r_acc[ACC_W-1:8]));
        r_c_row  <= r_b_row;
        r_c_cerr <= r_b_cerr;
    end

    // Clip when the bits above bit 31 are not all copies of the sign
    assign w_sat = !((&r_c_tot[TOT_W-1:WORD_W-1]) || !(|r_c_tot[TOT_W-1:WORD_W-1]));

    always_comb begin
        o_push       = r_c_valid;
        o_res.sat    = w_sat;
        o_res.cerr   = r_c_cerr;
        o_res.row    = r_c_row;
        if (w_sat) begin
            o_res.value = r_c_tot[TOT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            o_res.value = r_c_tot[WORD_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ src/dlf_res_fifo.sv @@
`default_nettype none
module dlf_res_fifo
    import dlf_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_push,
    input  t_result i_data,
    input  wire     i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [PEND_W-1:0]   r_cnt;
    logic                w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/dense_layer_forward_mac_core.sv @@
`default_nettype none
// Fixed-point dense-layer forward multiply-accumulate.
// Input stream (s_*): one transaction per item, kind on s_tuser: load an
// activation into the buffer, stream one weight of the current row, or close
// the row with its bias and prior output. Weights of a row arrive in column
// order; each multiplies the buffered activation at the running column into a
// 48-bit accumulator. Output stream (m_*): one transaction per closed row,
// carrying the saturated Q16.16 result, the row number and two status flags.
// Configuration: APB register input_count at byte address 0.
// Throughput: one item per cycle, any mix of kinds, while s_tready is high. The
// activation buffer is one RAM with a write port and a registered read port.
// Result path: a closing item reaches m_tvalid through the read, multiply and
// accumulate stages, then the result queue.
// Reset clears the accumulator, column, row and excess state and the result
// queue; activation buffer contents stay undefined until loaded.
// Stall: an 8-entry result queue absorbs rows while m_tready is low; s_tready
// drops only when 8 rows are outstanding, so weights keep flowing meanwhile.
module dense_layer_forward_mac_core
    import dlf_pkg::*;
#(
    parameter int INPUT_MAX  = INPUT_MAX_DEF,
    parameter int OUTPUT_MAX = OUTPUT_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // index[9:0], value[25:10], bias[57:26],
                                   // prior_output[89:58], zero[95:90]
    input  wire  [1:0]  s_tuser,   // mode[1:0]
    // Output stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // result_value[31:0], row_number[41:32],
                                   // count_error[42], saturated[43], zero[47:44]
);

    localparam int AW    = (INPUT_MAX > 1) ? $clog2(INPUT_MAX) : 1;
    localparam int CW    = $clog2(INPUT_MAX + 1);
    localparam int ROW_W = (OUTPUT_MAX > 1) ? $clog2(OUTPUT_MAX) : 1;

    // Clamp the programmed count into 1..INPUT_MAX
    function automatic logic [CW-1:0] f_eff(input logic [CNT_W-1:0] v);
        logic [31:0] c;
        begin
            c = 32'(v);
            if (c == 32'd0) begin
                c = 32'd1;
            end
            if (c > 32'(INPUT_MAX)) begin
                c = 32'(INPUT_MAX);
            end
            f_eff = CW'(c);
        end
    endfunction

    logic [CNT_W-1:0]        r_cnt_reg;
    logic [CW-1:0]           r_eff;
    logic [CW-1:0]           r_col;
    logic [ROW_W-1:0]        r_row;
    logic                    r_excess;
    logic [PEND_W-1:0]       r_pend;
    t_stage_a                r_a;
    t_stage_a                n_a;

    logic                    w_cfg_wr;
    logic                    w_acc;
    logic [MODE_W-1:0]       w_mode;
    logic [INDEX_W-1:0]      w_index;
    logic [VALUE_W-1:0]      w_value;
    logic [WORD_W-1:0]       w_bias;
    logic [WORD_W-1:0]       w_prior;
    logic                    w_act_wr;
    logic                    w_wgt;
    logic                    w_mac;
    logic                    w_close;
    logic                    w_out_hs;
    logic [31:0]             w_row_ext;
    logic [VALUE_W-1:0]      w_act;
    logic                    w_push;
    t_result                 w_push_res;
    t_result                 w_out_res;

    // Unpack the input transaction
    assign w_mode  = s_tuser;
    assign w_index = s_tdata[9:0];
    assign w_value = s_tdata[25:10];
    assign w_bias  = s_tdata[57:26];
    assign w_prior = s_tdata[89:58];

    // APB: single register, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? 32'(r_cnt_reg) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_reg <= CNT_RESET;
            r_eff     <= f_eff(CNT_RESET);
        end else if (w_cfg_wr) begin
            r_cnt_reg <= pwdata[CNT_W-1:0];
            r_eff     <= f_eff(pwdata[CNT_W-1:0]);
        end
    end

    // Hold the input while 8 rows are outstanding, so the queue never overflows
    assign s_tready = (r_pend < PEND_W'(FIFO_DEPTH));
    assign w_acc    = s_tvalid && s_tready;
    assign w_act_wr = w_acc && (w_mode == MODE_ACT) && (32'(w_index) < 32'(INPUT_MAX));
    assign w_wgt    = w_acc && (w_mode == MODE_WEIGHT);
    assign w_mac    = w_wgt && (r_col < r_eff);
    assign w_close  = w_acc && (w_mode == MODE_BIAS);
    assign w_out_hs = m_tvalid && m_tready;
    assign w_row_ext = 32'(r_row);

    // Column, row and excess bookkeeping advance at the accepting edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_excess <= 1'b0;
        end else if (w_close) begin
            r_col    <= '0;
            r_excess <= 1'b0;
            if (r_row == ROW_W'(OUTPUT_MAX - 1)) begin
                r_row <= '0;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end else if (w_mac) begin
            r_col <= r_col + 1'b1;
        end else if (w_wgt) begin
            // Drop the excess weight, remember it for the row's status
            r_excess <= 1'b1;
        end
    end

    // Rows accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({w_close, w_out_hs})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    // Pipeline entry, aligned with the activation read
    always_comb begin
        n_a.mac    = w_mac;
        n_a.close  = w_close;
        n_a.weight = $signed(w_value);
        n_a.bias   = $signed(w_bias);
        n_a.prior  = $signed(w_prior);
        n_a.row    = w_row_ext[ROWN_W-1:0];
        n_a.cerr   = r_excess || (r_col != r_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else begin
            r_a <= n_a;
        end
    end

    dlf_act_mem #(
        .DEPTH (INPUT_MAX),
        .AW    (AW)
    ) u_act_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_act_wr),
        .i_wr_addr (AW'(w_index)),
        .i_wr_data (w_value),
        .i_rd_en   (w_mac),
        .i_rd_addr (r_col[AW-1:0]),
        .o_rd_data (w_act)
    );

    dlf_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_a),
        .i_act   (w_act),
        .o_push  (w_push),
        .o_res   (w_push_res)
    );

    dlf_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_res),
        .i_pop   (m_tready),
        .o_valid (m_tvalid),
        .o_data  (w_out_res)
    );

    assign m_tdata = {4'd0, w_out_res.sat, w_out_res.cerr, w_out_res.row, w_out_res.value};

endmodule
`default_nettype wire

@@ tb/dense_layer_forward_mac_core_tb.sv @@
`default_nettype none
module dense_layer_forward_mac_core_tb;
    import dlf_pkg::*;

    // Mode 3 is unused by the block: it must be swallowed without a row
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int ACT_DEPTH    = INPUT_MAX_DEF;
    localparam int ROW_WRAP     = OUTPUT_MAX_DEF;
    // Margin for a closing item to clear the pipeline and the result queue
    localparam int SETTLE_CYCLES = 12;
    localparam int ITEM_TARGET   = 750;
    localparam int PHASE_ITEMS   = 75;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic signed [WORD_W-1:0]  bias;
        logic signed [WORD_W-1:0]  prior;
    } layer_item_t;

    typedef struct {
        logic [WORD_W-1:0] value;
        logic [ROWN_W-1:0] row;
        logic              cerr;
        logic              sat;
    } row_result_t;

    // Tracks the layer state and the queue of row outputs still to come
    class row_output_checker;
        logic signed [VALUE_W-1:0] act_mem [ACT_DEPTH];
        longint          dot_sum;
        int unsigned     column;
        logic [ROWN_W-1:0] row_num;
        bit              excess;
        logic [CNT_W-1:0] count_reg;
        int              mismatches;
        row_result_t     expected_rows[$];

        function new();
            foreach (act_mem[i]) act_mem[i] = '0;
            dot_sum     = 0;
            column      = 0;
            row_num     = '0;
            excess      = 1'b0;
            count_reg   = CNT_RESET;
            mismatches  = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] c);
            count_reg = c;
        endfunction

        // Zero acts as one, anything above the buffer depth as the depth
        function int unsigned active_count();
            if (count_reg == 0) return 1;
            if (count_reg > ACT_DEPTH) return ACT_DEPTH;
            return count_reg;
        endfunction

        function int outstanding();
            return expected_rows.size();
        endfunction

        function void absorb_item(layer_item_t it);
            longint      total;
            row_result_t r;
            int unsigned eff;
            eff = active_count();
            case (it.mode)
                MODE_ACT: begin
                    act_mem[it.index] = it.value;
                end
                MODE_WEIGHT: begin
                    if (column < eff) begin
                        dot_sum += longint'(act_mem[column]) * longint'(it.value);
                        column++;
                    end else begin
                        excess = 1'b1;
                    end
                end
                MODE_BIAS: begin
                    // Q8.24 sum down to Q16.16, rounding toward minus infinity
                    total = longint'(it.prior) + (dot_sum >>> 8) + longint'(it.bias);
                    r.sat = 1'b0;
                    if (total > SAT_HI) begin
                        total = SAT_HI;
                        r.sat = 1'b1;
                    end else if (total < SAT_LO) begin
                        total = SAT_LO;
                        r.sat = 1'b1;
                    end
                    r.value = total[WORD_W-1:0];
                    r.row   = row_num;
                    r.cerr  = excess || (column != eff);
                    expected_rows.push_back(r);
                    row_num = (row_num == ROW_WRAP - 1) ? '0 : row_num + 1'b1;
                    dot_sum = 0;
                    column  = 0;
                    excess  = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [ROWN_W-1:0] row, longint e, longint g);
            mismatches++;
            $display("mismatch on %s (row %0d): expected %0h got %0h", what, row, e, g);
        endtask

        task check_row(logic [47:0] word);
            row_result_t exp_r;
            row_result_t got;
            got.value = word[31:0];
            got.row   = word[41:32];
            got.cerr  = word[42];
            got.sat   = word[43];
            if (expected_rows.size() == 0) begin
                report_mismatch("unexpected row", got.row, 0, word);
            end else begin
                exp_r = expected_rows.pop_front();
                if (got.value !== exp_r.value)
                    report_mismatch("result_value", exp_r.row, exp_r.value, got.value);
                if (got.row !== exp_r.row)
                    report_mismatch("row_number", exp_r.row, exp_r.row, got.row);
                if (got.cerr !== exp_r.cerr)
                    report_mismatch("count_error", exp_r.row, exp_r.cerr, got.cerr);
                if (got.sat !== exp_r.sat)
                    report_mismatch("saturated", exp_r.row, exp_r.sat, got.sat);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // index[9:0], value[25:10], bias[57:26],
                            // prior_output[89:58], zero[95:90]
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // result_value[31:0], row_number[41:32],
                            // count_error[42], saturated[43], zero[47:44]

    row_output_checker row_check;
    bit act_loaded [ACT_DEPTH];   // entries written so far, so no weight reads garbage
    bit no_idle;                  // run both sides flat out while set
    int items_sent;

    dense_layer_forward_mac_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #16_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Check every row transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            row_check.check_row(m_tdata);
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Receiver back-pressure: alternate ready bursts and stalls
    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                m_tready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (m_tready) begin
                m_tready = 1'b0;
                hold = pick_gap() + 1;
            end else begin
                m_tready = 1'b1;
                hold = $urandom_range(1, 16);
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Full-range words saturate most rows, so keep many of them small
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    function automatic layer_item_t make_item(logic [MODE_W-1:0] m, int unsigned idx,
                                              logic signed [VALUE_W-1:0] v);
        layer_item_t it;
        it.mode  = m;
        it.index = idx[INDEX_W-1:0];
        it.value = v;
        it.bias  = pick_word();
        it.prior = pick_word();
        return it;
    endfunction

    function automatic layer_item_t close_item(logic signed [WORD_W-1:0] prior,
                                               logic signed [WORD_W-1:0] bias);
        layer_item_t it;
        it = make_item(MODE_BIAS, $urandom, 16'($urandom));
        it.prior = prior;
        it.bias  = bias;
        return it;
    endfunction

    // Drive one item at the falling edge, hold it until the transaction,
    // then hand it to the predictor
    task automatic send_item(layer_item_t it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, it.prior, it.bias, it.value, it.index};
        s_tuser  = it.mode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        row_check.absorb_item(it);
        if (it.mode == MODE_ACT) act_loaded[it.index] = 1'b1;
        items_sent++;
    endtask

    // Drop valid and hold off until every row is out and the pipe is empty
    task automatic drain_rows();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (row_check.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] c);
        drain_rows();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(4 * REG_INPUT_COUNT);
        pwdata  = 32'(c);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        row_check.set_count(c);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Fill every buffer entry the current row length can reach
    task automatic load_missing();
        for (int i = 0; i < row_check.active_count(); i++)
            if (!act_loaded[i]) send_item(make_item(MODE_ACT, i, pick_value()));
    endtask

    // One row: maybe a few loads, mostly the exact weight count, sometimes
    // short or with excess weights, spare-mode noise mixed in
    task automatic run_row();
        int eff;
        int n;
        int pick;
        eff = row_check.active_count();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_item(make_item(MODE_ACT, $urandom_range(0, ACT_DEPTH - 1), pick_value()));
        pick = $urandom_range(0, 99);
        if (pick < 70)      n = eff;
        else if (pick < 85) n = $urandom_range(0, eff - 1);
        else                n = eff + $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(make_item(MODE_SPARE, $urandom, 16'($urandom)));
            send_item(make_item(MODE_WEIGHT, $urandom, pick_value()));
        end
        send_item(make_item(MODE_BIAS, $urandom, pick_value()));
    endtask

    initial begin
        int phase_counts [8];
        int start;
        phase_counts = '{5, 0, 1, 12, 2, 33, 8, 3};
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        no_idle  = 1'b0;
        items_sent = 0;
        row_check = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: row length still at its reset value of 1024
        send_item(make_item(MODE_ACT, 0, 16'sh8000));
        send_item(make_item(MODE_ACT, 1, 16'sh7FFF));
        send_item(make_item(MODE_ACT, ACT_DEPTH - 1, 16'sh5A5A));
        send_item(make_item(MODE_SPARE, $urandom, 16'($urandom)));
        send_item(make_item(MODE_WEIGHT, 0, 16'sh8000));
        send_item(make_item(MODE_WEIGHT, 0, 16'sh7FFF));
        // Short rows, then saturation high and low
        send_item(close_item(32'sd0, 32'sd0));
        send_item(close_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_item(close_item(32'sh8000_0000, 32'sh8000_0000));

        // Zero length acts as one: exact row with a negative product,
        // then a row with an excess weight
        write_count(11'd0);
        send_item(make_item(MODE_WEIGHT, 0, 16'sh7FFF));
        send_item(close_item(32'sd1, -32'sd1));
        send_item(make_item(MODE_WEIGHT, 0, 16'sh0101));
        send_item(make_item(MODE_WEIGHT, 0, 16'sh8000));
        send_item(close_item(32'sd0, 32'sd0));

        write_count(11'd2);
        send_item(make_item(MODE_WEIGHT, 0, 16'sh8000));
        send_item(make_item(MODE_WEIGHT, 0, 16'sh8000));
        send_item(close_item(32'sh0001_0000, -32'sh0003_0000));
        // Overwrite an entry, then a small negative sum that is a
        // multiple of 256
        send_item(make_item(MODE_ACT, 0, -16'sd1));
        send_item(make_item(MODE_WEIGHT, 0, 16'sd1));
        send_item(make_item(MODE_WEIGHT, 0, -16'sd1));
        send_item(close_item(32'sd0, 32'sd0));

        // Largest register value clamps to the buffer depth: a short row
        // far below the depth, flat out on both sides
        write_count(11'd2047);
        no_idle = 1'b1;
        send_item(make_item(MODE_WEIGHT, $urandom, pick_value()));
        send_item(make_item(MODE_WEIGHT, $urandom, pick_value()));
        send_item(make_item(MODE_BIAS, $urandom, pick_value()));
        no_idle = 1'b0;

        // Random rows over several small row lengths
        foreach (phase_counts[p]) begin
            write_count(11'(phase_counts[p]));
            load_missing();
            no_idle = (p == 3);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                run_row();
                if ($urandom_range(0, 14) == 0) drain_rows();
            end
            no_idle = 1'b0;
        end

        // Top up the item count with cheap one-weight rows
        write_count(11'd1);
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1))
                send_item(make_item(MODE_WEIGHT, $urandom, pick_value()));
            send_item(make_item(MODE_BIAS, $urandom, pick_value()));
        end

        drain_rows();
        if (row_check.mismatches == 0 && row_check.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
